// ===== src/srpg_pkg.sv =====
// Package for the stepper ramp pulse generator: field widths, reset values,
// register indexes, action codes, state types and the ramp unit request/response structs.
// No dependencies.
package srpg_pkg;

	localparam int StepsW  = 31;
	localparam int HalfW   = 32;
	localparam int RampW   = 10;
	localparam int PerW    = 16;
	localparam int MulW    = RampW + 1;
	localparam int ProdW   = 28;
	localparam int AddW    = ProdW + 1;
	localparam int CntW    = 4;
	localparam int CfgIdxW = 3;

	localparam logic [RampW-1:0] RampLengthReset  = RampW'(50);
	localparam logic [PerW-1:0]  SlowPeriodReset  = PerW'(11000);
	localparam logic [PerW-1:0]  FastPeriodReset  = PerW'(7000);
	localparam logic [PerW-1:0]  PulseWidthReset  = PerW'(1200);
	localparam logic [PerW-1:0]  StartPeriodReset = PerW'(12000);

	localparam logic [CfgIdxW-1:0] CFG_RAMP_LENGTH  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_SLOW_PERIOD  = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] CFG_FAST_PERIOD  = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] CFG_PULSE_WIDTH  = CfgIdxW'(3);
	localparam logic [CfgIdxW-1:0] CFG_START_PERIOD = CfgIdxW'(4);

	// input item action codes
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef enum logic [1:0] {
		U_IDLE,
		U_DIV,
		U_MUL,
		U_FIN
	} srpg_ustate_t;

	typedef enum logic {
		T_IDLE,
		T_RAMP
	} srpg_tstate_t;

	typedef struct packed {
		logic             neg;
		logic             halve;
		logic [PerW-1:0]  dividend;
		logic [RampW-1:0] divisor;
		logic [MulW-1:0]  multiplier;
		logic [PerW-1:0]  slow;
	} srpg_req_t;

	typedef struct packed {
		logic            done;
		logic [PerW-1:0] period;
	} srpg_rsp_t;

endpackage

// ===== src/stepper_ramp_pulse_generator_core.sv =====
// Stepper ramp pulse generator: top level with configuration registers, move
// state, result register and the ramp period unit. Depends on srpg_pkg, srpg_ramp_unit.
// Results: a result is valid the cycle after the tick's transfer; a start gives none.
// Starts, odd ticks and ticks outside the ramp are taken back to back while the result
// register is free; an even ramp tick keeps in_ready low while the shared add/subtract
// unit runs 16 divide, 11 multiply and 1 saturate steps. Reset (arst_n low, async):
// registers take reset values, the move is empty, the pin is low, no result is pending.
module stepper_ramp_pulse_generator_core import srpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [PerW-1:0]    cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [StepsW-1:0]  steps,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PerW-1:0]    compare_value,
	output logic               pulse_level,
	output logic               direction_released
);

	// configuration registers
	logic [RampW-1:0] ramp_length_q;
	logic [PerW-1:0]  slow_period_q, fast_period_q, pulse_width_q, start_period_q;

	// move state
	logic [HalfW-1:0] half_left_q;
	logic [RampW-1:0] accel_q;
	logic [PerW-1:0]  period_q;
	logic             pin_q;
	srpg_tstate_t     state_q, state_d;

	// ramp unit handoff
	srpg_req_t req_q, req_d;
	srpg_rsp_t rsp;
	logic      go_q;

	// result register
	logic            out_valid_q;
	logic [PerW-1:0] compare_q;
	logic            level_q, released_q;

	logic [RampW-1:0] ramp_eff, accel_new;
	logic [RampW:0]   accel_inc;
	logic             accel_run, decel_run, even, need_ramp, out_free;
	logic             tick_xfer, start_xfer, moving;
	logic [PerW-1:0]  gap;

	// a ramp length of zero acts as one
	assign ramp_eff  = (ramp_length_q == '0) ? RampW'(1) : ramp_length_q;
	// advance the acceleration count, saturating at the ramp length
	assign accel_inc = {1'b0, accel_q} + 1'b1;
	assign accel_new = (accel_inc > {1'b0, ramp_eff}) ? ramp_eff : accel_inc[RampW-1:0];
	assign accel_run = accel_new < ramp_eff;
	// deceleration overrides acceleration once fewer than 2*ramp half-steps remain
	assign decel_run = half_left_q < HalfW'({ramp_eff, 1'b0});
	assign even      = ~half_left_q[0];
	assign need_ramp = even && (accel_run || decel_run);
	assign moving    = (half_left_q != '0);
	// gap floors at zero
	assign gap       = (period_q > pulse_width_q) ? (period_q - pulse_width_q) : '0;

	assign out_free   = ~out_valid_q | out_ready;
	assign tick_xfer  = in_valid & in_ready & (action == ACT_TICK);
	assign start_xfer = in_valid & in_ready & (action == ACT_START);
	assign cfg_ready  = 1'b1;

	// the ramp step sign is carried apart so the unit works on magnitudes
	always_comb begin
		req_d.neg        = slow_period_q < fast_period_q;
		req_d.dividend   = req_d.neg ? (fast_period_q - slow_period_q)
		                             : (slow_period_q - fast_period_q);
		req_d.divisor    = ramp_eff;
		req_d.halve      = decel_run;
		req_d.multiplier = decel_run ? half_left_q[MulW-1:0] : {1'b0, accel_new};
		req_d.slow       = slow_period_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: if (tick_xfer && need_ramp) state_d = T_RAMP;
			T_RAMP: if (rsp.done) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	// hold off new items while the period update runs; a result may drain meanwhile
	always_comb begin
		case (state_q)
			T_IDLE:  in_ready = out_free;
			T_RAMP:  in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_length_q  <= RampLengthReset;
			slow_period_q  <= SlowPeriodReset;
			fast_period_q  <= FastPeriodReset;
			pulse_width_q  <= PulseWidthReset;
			start_period_q <= StartPeriodReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RAMP_LENGTH:  ramp_length_q  <= cfg_data[RampW-1:0];
				CFG_SLOW_PERIOD:  slow_period_q  <= cfg_data;
				CFG_FAST_PERIOD:  fast_period_q  <= cfg_data;
				CFG_PULSE_WIDTH:  pulse_width_q  <= cfg_data;
				CFG_START_PERIOD: start_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_left_q <= '0;
			accel_q     <= '0;
			period_q    <= StartPeriodReset;
			pin_q       <= 1'b0;
			state_q     <= T_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= tick_xfer & need_ramp;
			if (start_xfer) begin
				// load the move; the pin level is kept
				half_left_q <= {steps, 1'b0};
				period_q    <= start_period_q;
				accel_q     <= '0;
			end else if (tick_xfer) begin
				if (even) accel_q <= accel_new;
				if (moving) begin
					half_left_q <= half_left_q - 1'b1;
					pin_q       <= ~pin_q;
				end
			end
			if (rsp.done) period_q <= rsp.period;
			if (tick_xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the unit request and the result payload at the tick transfer
	always_ff @(posedge clk) begin
		if (tick_xfer) begin
			req_q      <= req_d;
			compare_q  <= even ? pulse_width_q : gap;
			level_q    <= moving ? ~pin_q : pin_q;
			released_q <= ~moving;
		end
	end

	srpg_ramp_unit u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.req    (req_q),
		.rsp    (rsp)
	);

	assign out_valid          = out_valid_q;
	assign compare_value      = compare_q;
	assign pulse_level        = level_q;
	assign direction_released = released_q;

endmodule

// ===== src/srpg_ramp_unit.sv =====
// Ramp period unit: one shared add/subtract unit runs a restoring divide, a
// shift-add multiply and a final saturated add or subtract under a small sequencer.
// Depends on srpg_pkg.
module srpg_ramp_unit import srpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  srpg_req_t req,
	output srpg_rsp_t rsp
);

	srpg_ustate_t state_q, state_d;
	logic [CntW-1:0]  cnt_q;
	logic [RampW-1:0] rem_q;
	logic [PerW-1:0]  quo_q;
	logic [ProdW-1:0] acc_q;
	logic [PerW-1:0]  period_q;
	logic             done_q;

	logic [RampW:0]   trial;
	logic [ProdW-1:0] prod;
	logic [AddW-1:0]  op_a, op_b;
	logic             cin;
	logic [AddW:0]    sum;
	logic             ge;
	logic [PerW-1:0]  sat;

	assign trial = {rem_q, req.dividend[cnt_q]};
	// halve with truncation toward zero: done on the magnitude
	assign prod  = req.halve ? {1'b0, acc_q[ProdW-1:1]} : acc_q;

	always_comb begin
		case (state_q)
			U_DIV: begin
				op_a = AddW'(trial);
				op_b = ~AddW'(req.divisor);
				cin  = 1'b1;
			end
			U_MUL: begin
				op_a = {acc_q, 1'b0};
				op_b = req.multiplier[cnt_q] ? AddW'(quo_q) : '0;
				cin  = 1'b0;
			end
			U_FIN: begin
				op_a = AddW'(req.slow);
				op_b = req.neg ? AddW'(prod) : ~AddW'(prod);
				cin  = ~req.neg;
			end
			default: begin
				op_a = '0;
				op_b = '0;
				cin  = 1'b0;
			end
		endcase
	end

	assign sum = {1'b0, op_a} + {1'b0, op_b} + (AddW + 1)'(cin);
	assign ge  = sum[AddW];

	always_comb begin
		if (sum[AddW-1]) begin
			sat = '0;
		end else if (|sum[AddW-2:PerW]) begin
			sat = '1;
		end else begin
			sat = sum[PerW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE: if (go) state_d = U_DIV;
			U_DIV:  if (cnt_q == '0) state_d = U_MUL;
			U_MUL:  if (cnt_q == '0) state_d = U_FIN;
			U_FIN:  state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == U_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (go) begin
					cnt_q <= CntW'(PerW - 1);
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			U_DIV: begin
				rem_q <= ge ? sum[RampW-1:0] : trial[RampW-1:0];
				quo_q <= {quo_q[PerW-2:0], ge};
				if (cnt_q == '0) begin
					cnt_q <= CntW'(MulW - 1);
					acc_q <= '0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			U_MUL: begin
				acc_q <= sum[ProdW-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			U_FIN: begin
				period_q <= sat;
			end
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.period = period_q;

endmodule

// ===== src/srpg_checker.sv =====
// Port-level checks for the stepper ramp pulse generator and the bind that
// attaches them to the top level. Depends on srpg_pkg.
module srpg_checker import srpg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic               in_valid,
	input logic               in_ready,
	input logic               action,
	input logic               out_valid,
	input logic               out_ready,
	input logic [PerW-1:0]    compare_value,
	input logic               pulse_level,
	input logic               direction_released
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(compare_value)
		&& $stable(pulse_level) && $stable(direction_released))
		else $error("result changed while stalled");

	// a start transfer yields no result
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_START) |=> !out_valid)
		else $error("start produced a result");

	// every tick transfer yields a result in the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_TICK) |=> out_valid)
		else $error("tick produced no result");

	// the configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind stepper_ramp_pulse_generator_core srpg_checker u_srpg_checker (.*);

// ===== sim/stepper_ramp_pulse_checker.sv =====
// Scoreboard for the stepper ramp pulse generator: tracks register writes and
// transfers, predicts every tick result and compares it with the output channel.
// Depends on srpg_pkg.
`timescale 1ns / 100ps

module stepper_ramp_pulse_checker import srpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [PerW-1:0]    cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic [StepsW-1:0]  steps,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [PerW-1:0]    compare_value,
	input  logic               pulse_level,
	input  logic               direction_released,
	output int                 mismatches,
	output int                 pending
);

	localparam longint PerMax    = (longint'(1) << PerW) - 1;
	localparam int     ShownMax  = 10;

	typedef struct packed {
		logic [PerW-1:0] compare;
		logic            level;
		logic            released;
	} pulse_t;

	logic [RampW-1:0] ramp_len;
	logic [PerW-1:0]  slow_per;
	logic [PerW-1:0]  fast_per;
	logic [PerW-1:0]  pulse_w;
	logic [PerW-1:0]  start_per;

	logic [HalfW-1:0] half_left;
	logic [RampW-1:0] accel;
	logic [PerW-1:0]  cur_per;
	logic             pin;

	pulse_t pulse_q[$];
	pulse_t want;

	function automatic logic [PerW-1:0] clamp_period(longint v);
		if (v < 0)
			return '0;
		if (v > PerMax)
			return '1;
		return PerW'(v);
	endfunction

	// Advance the move by one compare tick and return the pin/compare outcome.
	function automatic pulse_t advance_tick();
		pulse_t r;
		longint ramp_n;
		longint rate;
		longint nxt;
		r.released = 1'b0;
		if (!half_left[0]) begin
			ramp_n = (ramp_len == '0) ? 1 : longint'(ramp_len);
			rate = (longint'(slow_per) - longint'(fast_per)) / ramp_n;
			nxt = longint'(accel) + 1;
			accel = (nxt > ramp_n) ? RampW'(ramp_n) : RampW'(nxt);
			if (longint'(accel) < ramp_n)
				cur_per = clamp_period(longint'(slow_per) - rate * longint'(accel));
			if (longint'(half_left) < 2 * ramp_n)
				cur_per = clamp_period(longint'(slow_per) - (rate * longint'(half_left)) / 2);
			r.compare = pulse_w;
		end else begin
			r.compare = (cur_per > pulse_w) ? cur_per - pulse_w : '0;
		end
		if (half_left != '0) begin
			half_left = half_left - 1'b1;
			pin = ~pin;
		end else begin
			r.released = 1'b1;
		end
		r.level = pin;
		return r;
	endfunction

	task automatic note_mismatch(string what, longint exp_v, longint got_v);
		if (mismatches < ShownMax)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		mismatches = mismatches + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_len = RampLengthReset;
			slow_per = SlowPeriodReset;
			fast_per = FastPeriodReset;
			pulse_w = PulseWidthReset;
			start_per = StartPeriodReset;
			half_left = '0;
			accel = '0;
			cur_per = StartPeriodReset;
			pin = 1'b0;
			pulse_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pulse_q.size() == 0) begin
					note_mismatch("unexpected result, compare_value", -1, compare_value);
				end else begin
					want = pulse_q.pop_front();
					if (compare_value !== want.compare)
						note_mismatch("compare_value", want.compare, compare_value);
					if (pulse_level !== want.level)
						note_mismatch("pulse_level", want.level, pulse_level);
					if (direction_released !== want.released)
						note_mismatch("direction_released", want.released, direction_released);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RAMP_LENGTH:  ramp_len = cfg_data[RampW-1:0];
					CFG_SLOW_PERIOD:  slow_per = cfg_data;
					CFG_FAST_PERIOD:  fast_per = cfg_data;
					CFG_PULSE_WIDTH:  pulse_w = cfg_data;
					CFG_START_PERIOD: start_per = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (action == ACT_START) begin
					half_left = {steps, 1'b0};
					cur_per = start_per;
					accel = '0;
				end else begin
					pulse_q.push_back(advance_tick());
				end
			end
			pending <= pulse_q.size();
		end
	end

endmodule

// ===== sim/stepper_ramp_pulse_generator_core_test.sv =====
// Top of the stepper ramp pulse generator testbench: clock, reset, register
// setups, move stimulus, output back-pressure, watchdog and final verdict.
// Depends on srpg_pkg, stepper_ramp_pulse_generator_core, stepper_ramp_pulse_checker.
`timescale 1ns / 100ps

module stepper_ramp_pulse_generator_core_test import srpg_pkg::*;;

	// First register index past the defined ones; writes there must be ignored.
	localparam logic [CfgIdxW-1:0] CFG_FIRST_SPARE = CFG_START_PERIOD + 1'b1;

	// An even ramp tick holds the input while the ramp unit runs; leave headroom.
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 132;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [PerW-1:0]    cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [StepsW-1:0]  steps;
	logic               out_valid;
	logic               out_ready;
	logic [PerW-1:0]    compare_value;
	logic               pulse_level;
	logic               direction_released;

	int send_idle;
	int recv_idle;
	int items_sent;
	int idle_cycles = 0;
	int mismatches;
	int pending;

	stepper_ramp_pulse_generator_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.action             (action),
		.steps              (steps),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.compare_value      (compare_value),
		.pulse_level        (pulse_level),
		.direction_released (direction_released)
	);

	stepper_ramp_pulse_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.action             (action),
		.steps              (steps),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.compare_value      (compare_value),
		.pulse_level        (pulse_level),
		.direction_released (direction_released),
		.mismatches         (mismatches),
		.pending            (pending)
	);

	// 8 ns period: 4 ns high, 4 ns low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver back-pressure: drop out_ready with a chance of recv_idle percent.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: count cycles without any transfer on any channel and abort when
	// the count reaches the limit.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one item on the input channel and hold it until its transfer.
	// The sender may idle first; with no idle, valid stays high across items.
	task automatic push_item(input logic act, input logic [StepsW-1:0] count);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		steps <= count;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and hold until every predicted result has come out, then let
	// the block finish any start or ramp work that produces no result.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Present one register write; valid stays high for a following write.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PerW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Bring the block to idle and write all five registers, optionally followed
	// by a write to an undefined index.
	task automatic load_setup(input logic [PerW-1:0] ramp_data, input logic [PerW-1:0] slow,
			input logic [PerW-1:0] fast, input logic [PerW-1:0] width,
			input logic [PerW-1:0] start, input logic spare);
		settle();
		write_reg(CFG_RAMP_LENGTH, ramp_data);
		write_reg(CFG_SLOW_PERIOD, slow);
		write_reg(CFG_FAST_PERIOD, fast);
		write_reg(CFG_PULSE_WIDTH, width);
		write_reg(CFG_START_PERIOD, start);
		if (spare)
			write_reg(CFG_FIRST_SPARE + CfgIdxW'($urandom_range(2)), PerW'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Period-like register value: mostly ordinary speeds, sometimes the extremes.
	function automatic logic [PerW-1:0] pick_period();
		case ($urandom_range(7))
			0: return PerW'(1);
			1: return '1;
			2: return PerW'($urandom);
			default: return PerW'($urandom_range(500, 20000));
		endcase
	endfunction

	initial begin : stim
		logic [PerW-1:0] ramp_data;
		int phase_end;
		int moves;
		int kind;
		logic held;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_TICK;
		steps = '0;
		send_idle = 10;
		recv_idle = 71;
		items_sent = 0;

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: tick with no move loaded (released, payload
		// ignored), empty move, then a short move run past its end.
		push_item(ACT_TICK, '1);
		push_item(ACT_START, '0);
		push_item(ACT_TICK, '0);
		push_item(ACT_START, StepsW'(3));
		repeat (8)
			push_item(ACT_TICK, '0);

		// Directed, corner settings: ramp length masked to zero, fast above slow
		// (negative ramp step), pulse width beyond the period (gap floors at zero),
		// then the largest step count.
		load_setup(16'hFC00, PerW'(1000), '1, '1, '1, 1'b0);
		push_item(ACT_START, StepsW'(2));
		repeat (5)
			push_item(ACT_TICK, '0);
		push_item(ACT_START, '1);
		repeat (2)
			push_item(ACT_TICK, '1);

		// Random phases: new settings each time, idling pattern by thirds.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				load_setup(PerW'(1), PerW'(1), PerW'(1), PerW'(1), PerW'(1), 1'b1);
			end else if (ph == 1) begin
				load_setup(PerW'(1023), '1, '1, '1, '1, 1'b0);
			end else begin
				case ($urandom_range(5))
					0: ramp_data = PerW'(1);
					1: ramp_data = PerW'(1023);
					2: ramp_data = PerW'($urandom_range(1, 16));
					3: ramp_data = PerW'($urandom_range(1, 1023));
					4: ramp_data = PerW'($urandom);
					default: ramp_data = PerW'($urandom_range(2, 8));
				endcase
				load_setup(ramp_data, pick_period(), pick_period(), pick_period(),
					pick_period(), 1'($urandom_range(1)));
			end

			if (ph < PHASES / 3) begin
				send_idle = 10;
				recv_idle = 71;
			end else if (ph < 2 * PHASES / 3) begin
				send_idle = 71;
				recv_idle = 10;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end

			phase_end = items_sent + PHASE_ITEMS;
			held = 1'b0;
			while (items_sent < phase_end) begin
				// Halfway through, hold the sender until the output side drains.
				if (!held && items_sent >= phase_end - PHASE_ITEMS / 2) begin
					settle();
					held = 1'b1;
				end
				kind = $urandom_range(99);
				if (kind < 80) begin
					// Complete move with a few ticks past its end.
					moves = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(24);
					push_item(ACT_START, StepsW'(moves));
					repeat (2 * moves + $urandom_range(3))
						push_item(ACT_TICK, StepsW'($urandom));
				end else if (kind < 90) begin
					// Move cut short by the next start, often a huge one.
					push_item(ACT_START, $urandom_range(1) ? StepsW'($urandom)
						: StepsW'($urandom_range(40)));
					repeat ($urandom_range(6))
						push_item(ACT_TICK, StepsW'($urandom));
				end else begin
					repeat ($urandom_range(1, 4))
						push_item(1'($urandom_range(1)), StepsW'($urandom));
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
